@@ rtl/core/lrupr_pkg.sv @@
// ============================================================================
// LRU page replacement shared definitions
// Constants, widths and the item types that pass between the front end, the
// back end and the top level.
// ============================================================================
`default_nettype none

package lrupr_pkg;

   // Frame store geometry.
   localparam int MAX_FRAMES = 16;
   localparam int PAGE_BITS  = 16;

   // Width of the page fields on the ports.
   localparam int PAGE_W  = 16;
   // Only the low PAGE_BITS bits of a page take part in the tag compare.
   localparam int TAG_W   = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
   // A rank is 0 for the most recent page up to MAX_FRAMES-1 for the oldest.
   localparam int RANK_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   // Occupancy and limits count from 0 up to MAX_FRAMES itself.
   localparam int COUNT_W = $clog2(MAX_FRAMES + 1);

   // Frame limit register.
   localparam int               LIMIT_W     = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);

   // Saturating fault counter.
   localparam int                FAULT_W   = 24;
   localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

   // Queue between the front end and the back end; a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One access waiting in the queue.
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             eos;
   } q_item_type;

   // One result as it leaves the back end.
   typedef struct packed {
      logic               page_hit;
      logic               victim_valid;
      logic [PAGE_W-1:0]  victim_page;
      logic [FAULT_W-1:0] fault_total;
      logic               string_done;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/core/lrupr_front.sv @@
// ============================================================================
// LRU page replacement front end
// Accepts page accesses, reduces the page to its tag and holds them in a
// short queue until the back end takes them.
// ============================================================================
`default_nettype none

module lrupr_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [lrupr_pkg::PAGE_W-1:0] in_page,
   input  wire logic                        in_eos,
   output logic                             q_valid,
   input  wire logic                        q_ready,
   output lrupr_pkg::q_item_type            q_item
);

   lrupr_pkg::q_item_type                 q_mem_ff [lrupr_pkg::QUEUE_DEPTH];
   logic [lrupr_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [lrupr_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [lrupr_pkg::QCNT_W-1:0]          count_ff, count_in;
   logic                                  push, pop;
   lrupr_pkg::q_item_type                 new_item;

   assign in_ready = (count_ff != lrupr_pkg::QCNT_W'(lrupr_pkg::QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign q_item   = q_mem_ff[rd_ptr_ff];

   assign push = in_valid && in_ready;
   assign pop  = q_valid && q_ready;

   always_comb begin
      new_item.tag = in_page[lrupr_pkg::TAG_W-1:0];
      new_item.eos = in_eos;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/lrupr_back.sv @@
// ============================================================================
// LRU page replacement back end
// Looks up each queued access in the frame store, updates the recency ranks
// and registers one result per access.
// ============================================================================
`default_nettype none

module lrupr_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [lrupr_pkg::COUNT_W-1:0] limit,
   input  wire logic                          q_valid,
   output logic                               q_ready,
   input  wire lrupr_pkg::q_item_type         q_item,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output lrupr_pkg::rsp_item_type            out_item
);

   localparam int N = lrupr_pkg::MAX_FRAMES;

   // Frame store. Tags are read only while their frame is valid.
   logic [lrupr_pkg::TAG_W-1:0]   page_ff [N];
   logic [N-1:0]                  valid_ff, valid_in;
   logic [lrupr_pkg::RANK_W-1:0]  rank_ff [N];
   logic [lrupr_pkg::RANK_W-1:0]  rank_in [N];
   logic [lrupr_pkg::COUNT_W-1:0] occ_ff, occ_in;
   logic [lrupr_pkg::FAULT_W-1:0] fault_ff, fault_in;

   logic                          out_valid_ff, out_valid_in;
   lrupr_pkg::rsp_item_type       out_item_ff, out_item_in;

   logic                          take;
   logic [N-1:0]                  hit_vec, free_vec, free_first, lru_vec, tgt_vec;
   logic                          hit, room;
   logic [lrupr_pkg::COUNT_W-1:0] lru_rank, hit_rank, old_rank;
   logic [lrupr_pkg::TAG_W-1:0]   victim_tag;

   assign q_ready   = !out_valid_ff || out_ready;
   assign take      = q_valid && q_ready;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   // Parallel tag compare, free frame search and oldest frame search.
   // Valid frames hold distinct ranks 0..occ-1, so the oldest is rank occ-1.
   always_comb begin
      lru_rank = occ_ff - 1'b1;
      for (int i = 0; i < N; i++) begin
         hit_vec[i]  = valid_ff[i] && (page_ff[i] == q_item.tag);
         free_vec[i] = !valid_ff[i];
         lru_vec[i]  = valid_ff[i] && (lrupr_pkg::COUNT_W'(rank_ff[i]) == lru_rank);
      end
      free_first = free_vec & (~free_vec + 1'b1);
      hit        = |hit_vec;
      room       = (occ_ff < limit);
   end

   always_comb begin
      hit_rank   = '0;
      victim_tag = '0;
      for (int i = 0; i < N; i++) begin
         if (hit_vec[i]) begin
            hit_rank = hit_rank | lrupr_pkg::COUNT_W'(rank_ff[i]);
         end
         if (lru_vec[i]) begin
            victim_tag = victim_tag | page_ff[i];
         end
      end
   end

   always_comb begin
      if (hit) begin
         tgt_vec  = hit_vec;
         old_rank = hit_rank;
      end else if (room) begin
         tgt_vec  = free_first;
         old_rank = occ_ff;
      end else begin
         tgt_vec  = lru_vec;
         old_rank = lru_rank;
      end
   end

   // Next state of the frame store.
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      fault_in = fault_ff;
      for (int i = 0; i < N; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (take) begin
         for (int i = 0; i < N; i++) begin
            if (tgt_vec[i]) begin
               rank_in[i]  = '0;
               valid_in[i] = 1'b1;
            end else if (valid_ff[i] &&
                         (lrupr_pkg::COUNT_W'(rank_ff[i]) < old_rank)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
         if (!hit) begin
            if (fault_ff != lrupr_pkg::FAULT_MAX) begin
               fault_in = fault_ff + 1'b1;
            end
            if (room) begin
               occ_in = occ_ff + 1'b1;
            end
         end
         // End of string empties every frame after the result is formed.
         if (q_item.eos) begin
            valid_in = '0;
            occ_in   = '0;
            fault_in = '0;
            for (int i = 0; i < N; i++) begin
               rank_in[i] = '0;
            end
         end
      end
   end

   // Result register.
   always_comb begin
      out_valid_in = take ? 1'b1 : (out_valid_ff && !out_ready);
      out_item_in  = out_item_ff;
      if (take) begin
         out_item_in.page_hit     = hit;
         out_item_in.victim_valid = !hit && !room;
         out_item_in.victim_page  = (!hit && !room) ?
                                    lrupr_pkg::PAGE_W'(victim_tag) : '0;
         out_item_in.fault_total  = hit ? fault_ff :
                                    ((fault_ff != lrupr_pkg::FAULT_MAX) ?
                                     fault_ff + 1'b1 : fault_ff);
         out_item_in.string_done  = q_item.eos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         occ_ff       <= '0;
         fault_ff     <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         fault_ff     <= fault_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < N; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
      for (int i = 0; i < N; i++) begin
         if (take && !hit && tgt_vec[i]) begin
            page_ff[i] <= q_item.tag;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/lru_page_replacement.sv @@
// ============================================================================
// LRU page replacement
// Fully associative page-frame model with least-recently-used replacement.
// ============================================================================
//
//  Channel   Direction  Carries                               Transfer when
//  req_*     in         one page access                       req_tvalid & req_tready
//  rsp_*     out        hit, victim, fault count, string end  rsp_tvalid & rsp_tready
//  csr_*     in         frames_in_use limit                   csr_wr_en high
//
// The block sustains one access per clock cycle while the result channel
// is not stalled. An access is written into the input queue, taken from
// there by the back end, and its result is registered before it is offered.
// The tag compare and the rank update over all frames are combinational.
// Reset empties the queue, all frames and the fault count and sets the frame
// limit to 5. A stalled result holds while the two-entry queue fills.
//
// Each request returns one result. A hit makes the page the most recent one.
// A miss counts a fault and fills the lowest free frame while fewer frames
// than the limit are occupied; otherwise the least recently used page is
// evicted and reported. An access marked with tlast reports as usual and
// then empties all frames and clears the fault count.
// ============================================================================
`default_nettype none

module lru_page_replacement (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] page_number
   input  wire logic        req_tlast,   // end_of_string
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [15:0] victim_page, [39:16] fault_total
   output logic [1:0]       rsp_tuser,   // [0] page_hit, [1] victim_valid
   output logic             rsp_tlast,   // string_done
   // Frame limit register.
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data  // frames_in_use
);

   logic [lrupr_pkg::LIMIT_W-1:0] frames_ff, frames_in;
   logic [lrupr_pkg::COUNT_W-1:0] limit;

   logic                          q_valid, q_ready;
   lrupr_pkg::q_item_type         q_item;
   lrupr_pkg::rsp_item_type       out_item;

   // Frame limit register; user writes it only while the block is idle, unchecked.
   assign frames_in = csr_wr_en ? csr_wr_data : frames_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= lrupr_pkg::LIMIT_RESET;
      end else begin
         frames_ff <= frames_in;
      end
   end

   // A limit of zero acts as one frame, and any value above the store size
   // acts as the full store.
   always_comb begin
      if (frames_ff == '0) begin
         limit = lrupr_pkg::COUNT_W'(1);
      end else if (32'(frames_ff) > 32'(lrupr_pkg::MAX_FRAMES)) begin
         limit = lrupr_pkg::COUNT_W'(lrupr_pkg::MAX_FRAMES);
      end else begin
         limit = lrupr_pkg::COUNT_W'(frames_ff);
      end
   end

   lrupr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_page  (req_tdata),
      .in_eos   (req_tlast),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_item   (q_item)
   );

   lrupr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {out_item.fault_total, out_item.victim_page};
   assign rsp_tuser = {out_item.victim_valid, out_item.page_hit};
   assign rsp_tlast = out_item.string_done;

endmodule

`default_nettype wire

@@ rtl/core/lrupr_checker.sv @@
// ============================================================================
// LRU page replacement port checker
// Watches the top-level ports and flags results that break the block rules.
// ============================================================================
`default_nettype none

module lrupr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // No result is offered in the first cycle after reset is released.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result offered right after reset");

   // A stalled result holds its contents.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A hit never evicts a page.
   a_hit_no_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1])
      else $error("hit reported with a victim");

   // Without a victim the victim page reads as zero.
   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[15:0] == 16'd0)
      else $error("victim page set without a victim");

   // A fault is counted, so its fault total is never zero.
   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[39:16] != 24'd0)
      else $error("fault reported with a zero fault total");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

@@ tb/sv/lru_page_replacement_check.sv @@
`timescale 1ns / 1ps
// ============================================================================
// LRU page replacement result checker
// Watches the access, result and frame limit channels, keeps its own copy of
// the frame store and recency order, and compares every result transfer
// field by field with the oldest predicted result.
// ============================================================================

module lru_page_replacement_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data,
   output int               results_owed,
   output int               fail_count
);

   // Predicted results wait in a ring until their transfer.
   localparam int OWED_DEPTH = 256;

   logic [lrupr_pkg::TAG_W-1:0]   frame_tag [lrupr_pkg::MAX_FRAMES];
   logic                          frame_held [lrupr_pkg::MAX_FRAMES];
   int                            frame_age [lrupr_pkg::MAX_FRAMES];
   int                            held_count;
   logic [lrupr_pkg::FAULT_W-1:0] fault_tally;
   logic [lrupr_pkg::LIMIT_W-1:0] frame_limit;

   lrupr_pkg::rsp_item_type       owed_ring [OWED_DEPTH];
   int                            owed_head = 0;
   int                            owed_tail = 0;
   int                            owed_count = 0;
   int                            mismatches = 0;
   int                            results_seen = 0;

   assign fail_count = mismatches;

   function automatic void owe_result(input lrupr_pkg::rsp_item_type r);
      owed_ring[owed_tail] = r;
      owed_tail = (owed_tail + 1) % OWED_DEPTH;
      owed_count++;
   endfunction

   function automatic lrupr_pkg::rsp_item_type settle_result();
      lrupr_pkg::rsp_item_type r;
      r = owed_ring[owed_head];
      owed_head = (owed_head + 1) % OWED_DEPTH;
      owed_count--;
      return r;
   endfunction

   function automatic void empty_frames();
      int i;
      for (i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
         frame_tag[i]  = '0;
         frame_held[i] = 1'b0;
         frame_age[i]  = 0;
      end
      held_count  = 0;
      fault_tally = '0;
   endfunction

   // Frame f becomes the most recent; every resident frame that was newer
   // than its old age moves one step older.
   function automatic void make_newest(input int f, input int old_age);
      int i;
      for (i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
         if (frame_held[i] && i != f && frame_age[i] < old_age) frame_age[i]++;
      end
      frame_age[f] = 0;
   endfunction

   function automatic lrupr_pkg::rsp_item_type access_page(
      input logic [lrupr_pkg::PAGE_W-1:0] page, input logic eos);
      int                      i;
      int                      hit_at;
      int                      slot;
      int                      oldest;
      int                      cap;
      lrupr_pkg::rsp_item_type res;
      hit_at = -1;
      slot   = -1;
      oldest = 0;
      res    = '0;
      // A limit of zero behaves as one frame, anything above the store size
      // as the whole store.
      cap = int'(frame_limit);
      if (cap < 1) cap = 1;
      if (cap > lrupr_pkg::MAX_FRAMES) cap = lrupr_pkg::MAX_FRAMES;
      for (i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
         if (hit_at < 0 && frame_held[i] && frame_tag[i] == page[lrupr_pkg::TAG_W-1:0])
            hit_at = i;
      end
      if (hit_at >= 0) begin
         res.page_hit = 1'b1;
         make_newest(hit_at, frame_age[hit_at]);
      end else begin
         if (fault_tally != lrupr_pkg::FAULT_MAX) fault_tally++;
         if (held_count < cap) begin
            for (i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
               if (slot < 0 && !frame_held[i]) slot = i;
            end
         end
         if (slot >= 0) begin
            frame_held[slot] = 1'b1;
            frame_tag[slot]  = page[lrupr_pkg::TAG_W-1:0];
            make_newest(slot, held_count);
            held_count++;
         end else begin
            // Frames above a lowered limit stay resident, so the victim is
            // the oldest of all resident frames.
            for (i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
               if (frame_held[i] && (slot < 0 || frame_age[i] > oldest)) begin
                  slot   = i;
                  oldest = frame_age[i];
               end
            end
            if (slot >= 0) begin
               res.victim_valid = 1'b1;
               res.victim_page  = lrupr_pkg::PAGE_W'(frame_tag[slot]);
               frame_tag[slot]  = page[lrupr_pkg::TAG_W-1:0];
               make_newest(slot, oldest);
            end
         end
      end
      res.fault_total = fault_tally;
      res.string_done = eos;
      if (eos) empty_frames();
      return res;
   endfunction

   task automatic compare_field(input string name,
                                input logic [lrupr_pkg::FAULT_W-1:0] want,
                                input logic [lrupr_pkg::FAULT_W-1:0] got);
      if (want !== got) begin
         if (mismatches < 10) begin
            $display("%t result %0d: %s expected %0h, got %0h",
                     $realtime, results_seen, name, want, got);
         end
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      lrupr_pkg::rsp_item_type want;
      if (reset) begin
         empty_frames();
         frame_limit = lrupr_pkg::LIMIT_RESET;
         owed_head   = 0;
         owed_tail   = 0;
         owed_count  = 0;
      end else begin
         if (csr_wr_en) frame_limit = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (owed_count == 0) begin
               if (mismatches < 10) begin
                  $display("%t result %0d arrived with none outstanding: tdata %h tuser %b",
                           $realtime, results_seen, rsp_tdata, rsp_tuser);
               end
               mismatches++;
            end else begin
               want = settle_result();
               compare_field("page_hit", lrupr_pkg::FAULT_W'(want.page_hit),
                             lrupr_pkg::FAULT_W'(rsp_tuser[0]));
               compare_field("victim_valid", lrupr_pkg::FAULT_W'(want.victim_valid),
                             lrupr_pkg::FAULT_W'(rsp_tuser[1]));
               compare_field("victim_page", lrupr_pkg::FAULT_W'(want.victim_page),
                             lrupr_pkg::FAULT_W'(rsp_tdata[15:0]));
               compare_field("fault_total", want.fault_total, rsp_tdata[39:16]);
               compare_field("string_done", lrupr_pkg::FAULT_W'(want.string_done),
                             lrupr_pkg::FAULT_W'(rsp_tlast));
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) owe_result(access_page(req_tdata, req_tlast));
      end
      results_owed <= owed_count;
   end

endmodule

@@ tb/sv/lru_page_replacement_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// LRU page replacement testbench
// Drives page accesses with random gaps and result back-pressure, moves the
// frame limit through its extremes between reference strings, and lets the
// checker predict and compare every result.
// ============================================================================

module lru_page_replacement_test;

   // Clock and the one reset at the start of the run.
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   // Access channel; all inputs are at known values from time zero.
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;      // [15:0] page_number
   logic        req_tlast = 1'b0;    // end_of_string

   // Result channel.
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [15:0] victim_page, [39:16] fault_total
   logic [1:0]  rsp_tuser;           // [0] page_hit, [1] victim_valid
   logic        rsp_tlast;           // string_done

   // Frame limit register.
   logic        csr_wr_en = 1'b0;
   logic [4:0]  csr_wr_data = '0;    // frames_in_use

   int          results_owed;
   int          fail_count;

   // While set, neither side inserts gaps, so full-rate stretches occur.
   bit          steady = 1'b0;
   int          accesses_sent = 0;
   int          ready_hold = 0;

   lru_page_replacement i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lru_page_replacement_check i_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .results_owed (results_owed),
      .fail_count   (fail_count)
   );

   // 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Gap length for either side: mostly none, often short, and now and then a
   // long one that lets the two-entry queue fill or drain.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // The result side stalls at random. A stall starts only after ready has
   // been high, so stalls fall on every phase of the block's work.
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         rsp_tready <= 1'b0;
         ready_hold--;
      end else begin
         rsp_tready <= 1'b1;
         ready_hold = pick_gap();
      end
   end

   // One access: present it, hold it until the transfer, then either keep
   // valid high for the next access or drop it for a random gap. Valid gets
   // one assignment per time step.
   task automatic send_access(input logic [15:0] page, input logic eos);
      int gap;
      req_tdata  <= page;
      req_tlast  <= eos;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accesses_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every predicted result has come back. The
   // checker's count is registered, so the wait passes a clock edge with valid
   // low before the count is trusted.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   // The limit is only written with the block idle. Every access returns a
   // result, so an empty result queue means nothing is left in flight.
   task automatic write_limit(input logic [4:0] frames);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= frames;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One reference string drawn mostly from a small working set, so that hits,
   // fills and evictions all occur. Without the end mark the string carries
   // on into the next phase, under whatever limit that phase writes.
   task automatic send_string(input int length, input bit terminate);
      logic [15:0] hot_pages [20];
      int          pool_size;
      int          n;
      logic [15:0] page;
      pool_size = $urandom_range(1, 20);
      for (n = 0; n < pool_size; n++) hot_pages[n] = 16'($urandom_range(0, 65535));
      for (n = 0; n < length; n++) begin
         if ($urandom_range(0, 99) < 85) page = hot_pages[$urandom_range(0, pool_size - 1)];
         else page = 16'($urandom_range(0, 65535));
         send_access(page, terminate && n == length - 1);
      end
   endtask

   initial begin
      int phase;
      int strings;
      int s;
      logic [4:0] frames;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset limit of five frames: both page extremes, a hit, filling all
      // five frames, then two misses that evict the oldest pages, the last
      // of them closing the string.
      send_access(16'h0000, 1'b0);
      send_access(16'hFFFF, 1'b0);
      send_access(16'h0000, 1'b0);
      send_access(16'hAAAA, 1'b0);
      send_access(16'h5555, 1'b0);
      send_access(16'h1234, 1'b0);
      send_access(16'h8000, 1'b0);
      send_access(16'hFFFF, 1'b1);

      // A limit of zero behaves as a single frame.
      write_limit(5'd0);
      send_access(16'h0007, 1'b0);
      send_access(16'h0007, 1'b0);
      send_access(16'h0009, 1'b1);

      // Lowering the limit in the middle of a string: the four resident
      // pages stay, and each later miss replaces the oldest one.
      write_limit(5'd4);
      send_access(16'h0001, 1'b0);
      send_access(16'h0002, 1'b0);
      send_access(16'h0003, 1'b0);
      send_access(16'h0004, 1'b0);
      write_limit(5'd2);
      send_access(16'h0005, 1'b0);
      send_access(16'h0002, 1'b0);
      send_access(16'h0006, 1'b1);

      // Random phases. The first two use the largest settings, one above the
      // store size; later ones favor the extremes. Each write waits for the
      // block to drain completely before the sender resumes.
      phase = 0;
      while (accesses_sent < 370) begin
         if (phase == 0) frames = 5'd31;
         else if (phase == 1) frames = 5'd16;
         else begin
            case ($urandom_range(0, 5))
               0:       frames = 5'd0;
               1:       frames = 5'd1;
               2:       frames = 5'd16;
               3:       frames = 5'd31;
               default: frames = 5'($urandom_range(0, 31));
            endcase
         end
         write_limit(frames);
         steady  = ($urandom_range(0, 3) == 0);
         strings = $urandom_range(1, 3);
         for (s = 0; s < strings; s++) begin
            send_string($urandom_range(1, 40),
                        s < strings - 1 || $urandom_range(0, 3) != 0);
         end
         phase++;
      end
      steady = 1'b0;

      // Let any stray result surface before the verdict.
      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("lru_page_replacement_test: PASS");
      end else begin
         $display("lru_page_replacement_test: FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #10ms;
      $display("lru_page_replacement_test: FAIL");
      $finish;
   end

endmodule
